### hdl/string_escape_decoder_top_assert.svh
// Assertion macros shared by the checker. Each use stands on a line of its own.
// The enclosing module must provide clk and rst_n.
`ifndef STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/esd_pkg.sv
package esd_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // One decoded input byte: one or two result bytes.
  typedef struct packed {
    logic [7:0] data0;
    logic       last0;
    logic       has_second;
    logic [7:0] data1;
    logic       last1;
  } esd_cmd_t;

  function automatic logic is_octal(input logic [7:0] c);
    is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // Byte that follows a backslash and is not an octal digit.
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] v;
    unique case (c)
      CH_B:    v = CTL_BS;
      CH_F:    v = CTL_FF;
      CH_N:    v = CTL_LF;
      CH_R:    v = CTL_CR;
      CH_T:    v = CTL_HT;
      default: v = c;
    endcase
    escape_map = v;
  endfunction

endpackage

### hdl/string_escape_decoder_top.sv
// String escape decoder. Escaped string bytes arrive on the in_ stream, one per transfer, with
// in_tlast on the final byte of a string; decoded bytes leave on the out_ stream with out_tlast
// on the final decoded byte. A quote makes the next byte literal, a backslash followed by b, f,
// n, r or t gives the matching control byte, a backslash followed by one to three octal digits
// gives their value modulo 256, and any other escaped byte passes through. A non-octal byte that
// ends a digit run first releases the octal value, so one input byte can give two output bytes.
// The input side accepts one byte per clock cycle as long as the command queue between the
// decoding front end and the output back end has room; the output side delivers one byte per
// cycle while out_tready is high, so a byte that yields two results takes two output transfers,
// and the queue of QUEUE_DEPTH entries absorbs those bursts. A result passes through the queue
// and then the registered output stage before it appears on out_tvalid. No configuration and no
// clearing pass: the block is ready straight after reset.
module string_escape_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  // Result stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_last
);
  import esd_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     push;
  logic     in_xfer;
  esd_cmd_t cmd;
  esd_cmd_t q_head;

  // The front end may take a byte whenever the queue has a free entry; a byte that produces
  // no result still needs that guarantee only for simplicity of the handshake.
  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  // Front end: tracks the escape mode and turns each input transfer into at most one
  // queue entry holding one or two decoded bytes.
  esd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .cmd     (cmd)
  );

  // Short queue that decouples decoding from output stalls.
  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Back end: registered output that emits the bytes of each entry in turn.
  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

### hdl/esd_front.sv
module esd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             push,
  output esd_pkg::esd_cmd_t cmd
);
  import esd_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_QUOTE,
    MODE_BSLASH,
    MODE_OCTAL
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] oct_val_r, oct_val_nxt;
  logic [1:0] oct_dig_r, oct_dig_nxt;

  logic       c_is_oct;
  logic       c_is_esc;
  logic [7:0] oct_step;

  assign c_is_oct = is_octal(in_byte);
  assign c_is_esc = (in_byte == CH_QUOTE) || (in_byte == CH_BSLASH);
  // The low three bits of an octal digit character are its value.
  assign oct_step = {oct_val_r[4:0], in_byte[2:0]};

  always_comb begin
    mode_nxt    = mode_r;
    oct_val_nxt = oct_val_r;
    oct_dig_nxt = oct_dig_r;
    push        = 1'b0;
    cmd         = '0;
    if (accept) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (c_is_esc) begin
            if (in_last) begin
              push      = 1'b1;
              cmd.last0 = 1'b1;
            end else begin
              mode_nxt = (in_byte == CH_QUOTE) ? MODE_QUOTE : MODE_BSLASH;
            end
          end else begin
            push      = 1'b1;
            cmd.data0 = in_byte;
            cmd.last0 = in_last;
          end
        end
        MODE_QUOTE: begin
          mode_nxt  = MODE_NORMAL;
          push      = 1'b1;
          cmd.data0 = in_byte;
          cmd.last0 = in_last;
        end
        MODE_BSLASH: begin
          if (c_is_oct) begin
            if (in_last) begin
              push      = 1'b1;
              cmd.data0 = {5'd0, in_byte[2:0]};
              cmd.last0 = 1'b1;
            end else begin
              mode_nxt    = MODE_OCTAL;
              oct_val_nxt = {5'd0, in_byte[2:0]};
              oct_dig_nxt = 2'd1;
            end
          end else begin
            mode_nxt  = MODE_NORMAL;
            push      = 1'b1;
            cmd.data0 = escape_map(in_byte);
            cmd.last0 = in_last;
          end
        end
        MODE_OCTAL: begin
          if (c_is_oct) begin
            if (oct_dig_r >= 2'd2 || in_last) begin
              push        = 1'b1;
              cmd.data0   = oct_step;
              cmd.last0   = in_last;
              mode_nxt    = MODE_NORMAL;
              oct_val_nxt = '0;
              oct_dig_nxt = '0;
            end else begin
              oct_val_nxt = oct_step;
              oct_dig_nxt = oct_dig_r + 2'd1;
            end
          end else begin
            // Flush the run, then treat the byte as in normal mode.
            push        = 1'b1;
            cmd.data0   = oct_val_r;
            cmd.last0   = 1'b0;
            mode_nxt    = MODE_NORMAL;
            oct_val_nxt = '0;
            oct_dig_nxt = '0;
            if (c_is_esc) begin
              if (in_last) begin
                cmd.has_second = 1'b1;
                cmd.last1      = 1'b1;
              end else begin
                mode_nxt = (in_byte == CH_QUOTE) ? MODE_QUOTE : MODE_BSLASH;
              end
            end else begin
              cmd.has_second = 1'b1;
              cmd.data1      = in_byte;
              cmd.last1      = in_last;
            end
          end
        end
      endcase
      if (in_last) begin
        mode_nxt    = MODE_NORMAL;
        oct_val_nxt = '0;
        oct_dig_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      oct_val_r <= '0;
      oct_dig_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      oct_val_r <= oct_val_nxt;
      oct_dig_r <= oct_dig_nxt;
    end
  end

endmodule

### hdl/esd_queue.sv
module esd_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  esd_pkg::esd_cmd_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output esd_pkg::esd_cmd_t rd_data,
  output logic              empty
);
  import esd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  esd_cmd_t           entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/esd_back.sv
module esd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  esd_pkg::esd_cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import esd_pkg::*;

  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic       load;

  // The output register takes a new byte when empty or being drained.
  assign load = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    pend_last_nxt = pend_last_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = pend_byte_r;
        out_last_nxt = pend_last_r;
        pend_vld_nxt = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_vld_nxt   = 1'b1;
        out_byte_nxt  = q_data.data0;
        out_last_nxt  = q_data.last0;
        pend_vld_nxt  = q_data.has_second;
        pend_byte_nxt = q_data.data1;
        pend_last_nxt = q_data.last1;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_last_r <= pend_last_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

### hdl/esd_checker.sv
`include "string_escape_decoder_top_assert.svh"

module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic       out_stall;
  logic       in_xfer;
  logic [8:0] out_payload;

  assign out_stall   = out_tvalid && !out_tready;
  assign in_xfer     = in_tvalid && in_tready;
  assign out_payload = {out_tlast, out_tdata};

  // A stalled result transfer stays offered.
  `ESD_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "out_tvalid dropped")

  // A stalled result keeps its payload.
  `ESD_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload), "stalled result changed")

  // Input back-pressure only arises while a result is waiting at the output.
  `ESD_ASSERT_SAME(a_bp_cause, !in_tready, out_tvalid, "in_tready low with no pending result")

  // The queue only fills through an input transfer.
  `ESD_ASSERT_SAME(a_ready_fall, $fell(in_tready), $past(in_xfer), "in_tready fell, no transfer")

endmodule

bind string_escape_decoder_top esd_checker u_esd_checker (.*);
